// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high
`define GTPG_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define GTPG_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/gtpg_pkg.sv
// ----------------------------------------------------------------------------
// gtpg_pkg
// Shared widths, register codes, colour formats and control types of the
// grid test pattern generator.
// ----------------------------------------------------------------------------
`default_nettype none

package gtpg_pkg;

  // Field widths
  localparam int COORD_BITS   = 11;
  localparam int INDEX_BITS   = 8;
  localparam int COLOR_BITS   = 24;
  localparam int CHAN_BITS    = 8;
  localparam int CFG_IDX_BITS = 3;
  localparam int DIV_CNT_BITS = $clog2(COORD_BITS);

  // Channel positions inside a colour word
  localparam int RED_LSB   = 16;
  localparam int GREEN_LSB = 8;

  // Last step of the cell size division
  localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(COORD_BITS - 1);

  // Register reset values
  localparam logic [COORD_BITS-1:0] HRES_RST  = COORD_BITS'(1024);
  localparam logic [COORD_BITS-1:0] VRES_RST  = COORD_BITS'(768);
  localparam logic [INDEX_BITS-1:0] GRID_RST  = INDEX_BITS'(1);
  localparam logic [INDEX_BITS-1:0] STEP_RST  = INDEX_BITS'(1);

  // Register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_HRES   = 3'd0,
    REG_VRES   = 3'd1,
    REG_GRID   = 3'd2,
    REG_FIRST  = 3'd3,
    REG_STEP   = 3'd4,
    REG_FORMAT = 3'd5
  } cfg_reg_t;

  // Colour formats
  typedef enum logic [1:0] {
    FMT_INDEXED = 2'd0,
    FMT_RGB555  = 2'd1,
    FMT_RGB565  = 2'd2,
    FMT_RGB888  = 2'd3
  } color_fmt_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic restart_load;  // clear raster position, load the dividers
    logic div_step;      // one quotient bit of the cell sizes
    logic mul_a;         // first product stage
    logic mul_b;         // index product stage
    logic emit;          // load the output register, advance raster
  } gtpg_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_last;      // current divider step is the final one
  } gtpg_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/grid_test_pattern_generator_top.sv
// ----------------------------------------------------------------------------
// grid_test_pattern_generator_top
// Raster pattern source: one pixel per item, screen cut into a square grid of
// equal cells, colour stepped per cell in indexed or direct RGB formats.
//
//   channel  dir  handshake              payload
//   in       in   in_valid / in_ready    restart
//   out      out  out_valid / out_ready  pixel_x pixel_y pixel_color
//                                        pixel_drawn frame_last
//   cfg      in   cfg_write              cfg_index cfg_data
//
// An ordinary pixel passes MUL_A, MUL_B and EMIT to reach the output register
// and the input reopens with it, so one item is in flight at a time. A restart
// item first runs the bit-serial divider, which finds both cell sizes one
// quotient bit per cycle. The colour path uses two registered product stages.
// The output register lets the next item in while a pixel waits.
// Synchronous reset loads the register defaults and clears the raster.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_test_pattern_generator_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output      logic                              in_ready,
  input  wire logic                              restart,
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      logic [gtpg_pkg::COORD_BITS-1:0]   pixel_x,
  output      logic [gtpg_pkg::COORD_BITS-1:0]   pixel_y,
  output      logic [gtpg_pkg::COLOR_BITS-1:0]   pixel_color,
  output      logic                              pixel_drawn,
  output      logic                              frame_last,
  input  wire logic                              cfg_write,
  input  wire logic [gtpg_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [gtpg_pkg::COLOR_BITS-1:0]   cfg_data
);

  gtpg_pkg::gtpg_cmd_t  cmd;
  gtpg_pkg::gtpg_stat_t stat;

  // Sequencer
  gtpg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Counters, divider, colour and output register
  gtpg_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .stat        (stat),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .pixel_drawn (pixel_drawn),
    .frame_last  (frame_last)
  );

endmodule

`default_nettype wire

// File: rtl/core/gtpg_ctrl.sv
// ----------------------------------------------------------------------------
// gtpg_ctrl
// Sequencer of the pattern generator: takes one item, runs the divider on a
// restart, steps the two product stages and hands the pixel to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module gtpg_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic               restart,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      gtpg_pkg::gtpg_cmd_t cmd,
  input  wire gtpg_pkg::gtpg_stat_t stat
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_MUL_A,
    ST_MUL_B,
    ST_EMIT
  } state_t;

  state_t state;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Command decode
  always_comb begin
    cmd              = '0;
    cmd.restart_load = accept && restart;
    cmd.div_step     = (state == ST_DIVIDE);
    cmd.mul_a        = (state == ST_MUL_A);
    cmd.mul_b        = (state == ST_MUL_B);
    cmd.emit         = (state == ST_EMIT) && out_free;
  end

  // State and handshake registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      // Output register fills on emit, empties when taken
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            in_ready <= 1'b0;
            state    <= restart ? ST_DIVIDE : ST_MUL_A;
          end
        end
        ST_DIVIDE: begin
          if (stat.div_last) begin
            state <= ST_MUL_A;
          end
        end
        ST_MUL_A: begin
          state <= ST_MUL_B;
        end
        ST_MUL_B: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            in_ready  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/gtpg_datapath.sv
// ----------------------------------------------------------------------------
// gtpg_datapath
// Registers, raster counters, bit-serial cell size dividers, colour products
// and the output register of the pattern generator.
// ----------------------------------------------------------------------------
`default_nettype none

module gtpg_datapath (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_write,
  input  wire logic [gtpg_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [gtpg_pkg::COLOR_BITS-1:0]        cfg_data,
  input  wire gtpg_pkg::gtpg_cmd_t                    cmd,
  output      gtpg_pkg::gtpg_stat_t                   stat,
  output      logic [gtpg_pkg::COORD_BITS-1:0]        pixel_x,
  output      logic [gtpg_pkg::COORD_BITS-1:0]        pixel_y,
  output      logic [gtpg_pkg::COLOR_BITS-1:0]        pixel_color,
  output      logic                                   pixel_drawn,
  output      logic                                   frame_last
);

  localparam int CB = gtpg_pkg::COORD_BITS;
  localparam int IB = gtpg_pkg::INDEX_BITS;
  localparam int KB = gtpg_pkg::CHAN_BITS;

  // Configuration registers
  logic [CB-1:0]                    hres;
  logic [CB-1:0]                    vres;
  logic [IB-1:0]                    grid_n;
  logic [gtpg_pkg::COLOR_BITS-1:0]  first_color;
  logic [IB-1:0]                    step;
  gtpg_pkg::color_fmt_t             fmt;

  // Raster state
  logic [CB-1:0] col_pos;
  logic [CB-1:0] line_pos;
  logic [IB-1:0] grid_col;
  logic [IB-1:0] grid_row;
  logic [CB-1:0] off_x;
  logic [CB-1:0] off_y;
  logic [CB-1:0] cell_w;
  logic [CB-1:0] cell_h;

  // Divider state
  logic [IB-1:0]                     rem_w;
  logic [IB-1:0]                     rem_h;
  logic [CB-1:0]                     quo_w;
  logic [CB-1:0]                     quo_h;
  logic [gtpg_pkg::DIV_CNT_BITS-1:0] div_cnt;

  // Product registers
  logic [KB-1:0] p_rown;
  logic [KB-1:0] p_col;
  logic [KB-1:0] p_row;
  logic [KB-1:0] p_sum;
  logic [KB-1:0] p_idx;
  logic          drawn;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hres        <= gtpg_pkg::HRES_RST;
      vres        <= gtpg_pkg::VRES_RST;
      grid_n      <= gtpg_pkg::GRID_RST;
      first_color <= '0;
      step        <= gtpg_pkg::STEP_RST;
      fmt         <= gtpg_pkg::FMT_INDEXED;
    end else if (cfg_write) begin
      unique case (gtpg_pkg::cfg_reg_t'(cfg_index))
        gtpg_pkg::REG_HRES:   hres        <= cfg_data[CB-1:0];
        gtpg_pkg::REG_VRES:   vres        <= cfg_data[CB-1:0];
        gtpg_pkg::REG_GRID:   grid_n      <= cfg_data[IB-1:0];
        gtpg_pkg::REG_FIRST:  first_color <= cfg_data;
        gtpg_pkg::REG_STEP:   step        <= cfg_data[IB-1:0];
        gtpg_pkg::REG_FORMAT: fmt         <= gtpg_pkg::color_fmt_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // Restoring divider step, one quotient bit per cycle for each axis
  logic [IB:0]   shl_w, shl_h;
  logic          ge_w, ge_h;
  logic [IB-1:0] rem_w_next, rem_h_next;
  logic [CB-1:0] quo_w_next, quo_h_next;

  always_comb begin
    shl_w      = {rem_w, quo_w[CB-1]};
    shl_h      = {rem_h, quo_h[CB-1]};
    ge_w       = shl_w >= {1'b0, grid_n};
    ge_h       = shl_h >= {1'b0, grid_n};
    rem_w_next = ge_w ? IB'(shl_w - {1'b0, grid_n}) : shl_w[IB-1:0];
    rem_h_next = ge_h ? IB'(shl_h - {1'b0, grid_n}) : shl_h[IB-1:0];
    quo_w_next = {quo_w[CB-2:0], ge_w};
    quo_h_next = {quo_h[CB-2:0], ge_h};
  end

  assign stat.div_last = (div_cnt == gtpg_pkg::DIV_LAST);

  always_ff @(posedge clk) begin
    if (cmd.restart_load) begin
      rem_w   <= '0;
      rem_h   <= '0;
      quo_w   <= hres;
      quo_h   <= vres;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem_w   <= rem_w_next;
      rem_h   <= rem_h_next;
      quo_w   <= quo_w_next;
      quo_h   <= quo_h_next;
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // Products, low byte only: every colour result wraps at eight bits or less
  logic [KB-1:0] m_rown, m_col, m_row, m_sum, m_idx;
  logic [KB-1:0] sum_cr, idx_base;

  assign sum_cr   = KB'(grid_col + grid_row);
  assign idx_base = KB'(p_rown + grid_col);
  assign m_rown   = grid_row * grid_n;
  assign m_col    = grid_col * step;
  assign m_row    = grid_row * step;
  assign m_sum    = sum_cr * step;
  assign m_idx    = idx_base * step;

  always_ff @(posedge clk) begin
    if (cmd.mul_a) begin
      p_rown <= m_rown;
      p_col  <= m_col;
      p_row  <= m_row;
      p_sum  <= m_sum;
      drawn  <= (cell_w != '0) && (cell_h != '0) && (grid_col < grid_n) && (grid_row < grid_n);
    end
    if (cmd.mul_b) begin
      p_idx <= m_idx;
    end
  end

  // Colour assembly
  logic [KB-1:0]                   red8, green8, blue8, index8;
  logic [KB-1:0]                   rmask, gmask, bmask;
  logic [gtpg_pkg::COLOR_BITS-1:0] color;

  always_comb begin
    red8   = KB'(first_color[gtpg_pkg::RED_LSB +: KB] + p_col);
    green8 = KB'(first_color[gtpg_pkg::GREEN_LSB +: KB] + p_row);
    blue8  = KB'(first_color[KB-1:0] + p_sum);
    index8 = KB'(first_color[KB-1:0] + p_idx);
    case (fmt)
      gtpg_pkg::FMT_RGB555: begin
        rmask = 8'h1F; gmask = 8'h1F; bmask = 8'h1F;
      end
      gtpg_pkg::FMT_RGB565: begin
        rmask = 8'h1F; gmask = 8'h3F; bmask = 8'h1F;
      end
      default: begin
        rmask = 8'hFF; gmask = 8'hFF; bmask = 8'hFF;
      end
    endcase
    if (fmt == gtpg_pkg::FMT_INDEXED) begin
      color = {{(gtpg_pkg::COLOR_BITS-IB){1'b0}}, index8[IB-1:0]};
    end else begin
      color = {red8 & rmask, green8 & gmask, blue8 & bmask};
    end
  end

  // Line and frame ends, cell stepping
  logic [CB-1:0] last_x, last_y;
  logic          end_line, end_frame;
  logic          wrap_x, wrap_y;

  always_comb begin
    last_x    = (hres == '0) ? '0 : CB'(hres - 1'b1);
    last_y    = (vres == '0) ? '0 : CB'(vres - 1'b1);
    end_line  = col_pos >= last_x;
    end_frame = end_line && (line_pos >= last_y);
    wrap_x    = ({1'b0, off_x} + 1'b1) >= {1'b0, cell_w};
    wrap_y    = ({1'b0, off_y} + 1'b1) >= {1'b0, cell_h};
  end

  // Raster position and cell sizes
  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos  <= '0;
      line_pos <= '0;
      grid_col <= '0;
      grid_row <= '0;
      off_x    <= '0;
      off_y    <= '0;
      cell_w   <= '0;
      cell_h   <= '0;
    end else if (cmd.restart_load) begin
      col_pos  <= '0;
      line_pos <= '0;
      grid_col <= '0;
      grid_row <= '0;
      off_x    <= '0;
      off_y    <= '0;
    end else if (cmd.div_step) begin
      if (stat.div_last) begin
        cell_w <= (grid_n == '0) ? '0 : quo_w_next;
        cell_h <= (grid_n == '0) ? '0 : quo_h_next;
      end
    end else if (cmd.emit) begin
      if (!end_line) begin
        col_pos <= col_pos + 1'b1;
        if (cell_w == '0) begin
          off_x <= '0;
        end else if (wrap_x) begin
          off_x <= '0;
          if (grid_col != '1) grid_col <= grid_col + 1'b1;
        end else begin
          off_x <= off_x + 1'b1;
        end
      end else begin
        col_pos  <= '0;
        grid_col <= '0;
        off_x    <= '0;
        if (end_frame) begin
          line_pos <= '0;
          grid_row <= '0;
          off_y    <= '0;
        end else begin
          line_pos <= line_pos + 1'b1;
          if (cell_h == '0) begin
            off_y <= '0;
          end else if (wrap_y) begin
            off_y <= '0;
            if (grid_row != '1) grid_row <= grid_row + 1'b1;
          end else begin
            off_y <= off_y + 1'b1;
          end
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel_x     <= col_pos;
      pixel_y     <= line_pos;
      pixel_color <= drawn ? color : '0;
      pixel_drawn <= drawn;
      frame_last  <= end_frame;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/gtpg_checker.sv
// ----------------------------------------------------------------------------
// gtpg_checker
// Port-level checks of the pattern generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gtpg_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [gtpg_pkg::COORD_BITS-1:0] pixel_x,
  input wire logic [gtpg_pkg::COLOR_BITS-1:0] pixel_color,
  input wire logic                            pixel_drawn
);

  // A stalled pixel holds
  `GTPG_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_color), "stalled pixel changed")

  // Pixels outside the grid carry no colour
  `GTPG_ASSERT(a_undrawn_black, clk, rst, out_valid && !pixel_drawn |-> pixel_color == '0, "undrawn pixel has colour")

  // One item in flight: the port closes after each acceptance
  `GTPG_ASSERT(a_one_in_flight, clk, rst, in_valid && in_ready |=> !in_ready, "second item taken while busy")

  // Reset empties the output register
  `GTPG_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "output valid after reset")

endmodule

bind grid_test_pattern_generator_top gtpg_checker u_gtpg_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .pixel_x     (pixel_x),
  .pixel_color (pixel_color),
  .pixel_drawn (pixel_drawn)
);

`default_nettype wire
